// ===== sv/vector3_normalize_core_assert.svh =====
// Assertion macros shared by the vector normalisation block.
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define VNORM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vnorm: check failed");

// Two expressions must always agree.
`define VNORM_ASSERT_EQ(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) == (b)) \
    else $error("vnorm: values disagree");

`endif

// ===== sv/vnorm_pkg.sv =====
`timescale 1ns / 1ps
package vnorm_pkg;

  localparam int unsigned LANES      = 3;
  localparam int unsigned COMP_W     = 32;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 31;

  // Magnitudes and signs that ride alongside the square root.
  typedef struct packed {
    logic [LANES-1:0][COMP_W-1:0] mag;
    logic [LANES-1:0]             neg;
  } vnorm_side_t;

endpackage

// ===== sv/vector3_normalize_core.sv =====
`timescale 1ns / 1ps
// Normalises a stream of three-component vectors given in signed Q16.16. Each
// transaction on the input gives exactly one on the output: the length in
// unsigned Q16.16 (floor of the exact square root of the sum of squares) and
// the three unit components in signed Q2.30, each truncated toward zero. An
// all-zero vector gives zero length, zero components and the zero_vector flag.
// Fully pipelined, it takes one vector in every cycle while the output is not
// stalled; a vector passes the lane squares, the lane sum, the 32-stage square
// root, the 31-stage dividers and the output register. Back-pressure on the
// output stalls the whole pipeline at once, so nothing is lost or repeated.
module vector3_normalize_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, lowest bit first: x_in[31:0], y_in[63:32], z_in[95:64]
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, lowest bit first: length_out[31:0], unit_x[63:32],
  // unit_y[95:64], unit_z[127:96]
  output logic [127:0] out_tdata,
  // out_tuser: zero_vector[0]
  output logic [0:0]   out_tuser
);

  localparam int unsigned L  = vnorm_pkg::LANES;
  localparam int unsigned ND = vnorm_pkg::DIV_STAGES;

  // The whole pipeline advances whenever the output register can take a result.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage one: magnitude and square in each lane.
  logic [L-1:0][31:0] mag1;
  logic [L-1:0]       neg1;
  logic [L-1:0][63:0] sq1;
  logic               vld1_r;

  genvar i;
  generate
    for (i = 0; i < L; i++) begin : g_lane
      vnorm_lane_sq u_sq (
        .clk   (clk),
        .en    (en),
        .comp  (in_tdata[32*i +: 32]),
        .mag_r (mag1[i]),
        .neg_r (neg1[i]),
        .sq_r  (sq1[i])
      );
    end
  endgenerate

  // Stage two merges the lanes: the sum of squares cannot exceed 3 * 2^62.
  logic [63:0]            sum_r;
  vnorm_pkg::vnorm_side_t side2_r;
  logic                   vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_tvalid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r        <= sq1[0] + sq1[1] + sq1[2];
      side2_r.mag  <= mag1;
      side2_r.neg  <= neg1;
    end
  end

  logic                   vld_s;
  logic [31:0]            root_s;
  vnorm_pkg::vnorm_side_t side_s;

  vnorm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld2_r),
    .rad      (sum_r),
    .side_in  (side2_r),
    .out_vld  (vld_s),
    .root     (root_s),
    .side_out (side_s)
  );

  // Three dividers share the length as divisor; lane zero carries it onward.
  logic [L-1:0][30:0] quot_d;
  logic [L-1:0]       neg_d;
  logic [L-1:0][31:0] len_d;

  generate
    for (i = 0; i < L; i++) begin : g_div
      vnorm_div u_div (
        .clk     (clk),
        .en      (en),
        .mag     (side_s.mag[i]),
        .neg     (side_s.neg[i]),
        .len     (root_s),
        .quot    (quot_d[i]),
        .neg_out (neg_d[i]),
        .len_out (len_d[i])
      );
    end
  endgenerate

  // Valid flags follow the divider stages.
  logic vld_d_r [1:ND];

  generate
    for (i = 0; i < ND; i++) begin : g_vld
      if (i == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_d_r[1] <= 1'b0;
          end else if (en) begin
            vld_d_r[1] <= vld_s;
          end
        end
      end else begin : g_tail
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_d_r[i+1] <= 1'b0;
          end else if (en) begin
            vld_d_r[i+1] <= vld_d_r[i];
          end
        end
      end
    end
  endgenerate

  // Output register: restore signs and force zeros for the all-zero vector.
  logic               zero_d;
  logic [L-1:0][31:0] unit_nxt;
  logic [127:0]       tdata_r;
  logic               zero_r;
  logic               tvalid_r;

  // The three lengths are equal; a zero length can only come from a zero vector.
  assign zero_d = (len_d[0] == 32'd0) && (len_d[1] == 32'd0) && (len_d[2] == 32'd0);

  always_comb begin
    for (int j = 0; j < L; j++) begin
      if (zero_d) begin
        unit_nxt[j] = '0;
      end else if (neg_d[j]) begin
        unit_nxt[j] = 32'd0 - {1'b0, quot_d[j]};
      end else begin
        unit_nxt[j] = {1'b0, quot_d[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (en) begin
      tvalid_r <= vld_d_r[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tdata_r <= {unit_nxt[2], unit_nxt[1], unit_nxt[0], len_d[0]};
      zero_r  <= zero_d;
    end
  end

  assign out_tvalid   = tvalid_r;
  assign out_tdata    = tdata_r;
  assign out_tuser[0] = zero_r;

  // The x component of a result must lie within plus or minus one in Q2.30.
  logic signed [31:0] unit_x_s;
  logic               unit_x_ok;
  assign unit_x_s  = out_tdata[63:32];
  assign unit_x_ok = (unit_x_s <= 32'sd1073741824) && (unit_x_s >= -32'sd1073741824);

`include "vector3_normalize_core_assert.svh"

  `VNORM_ASSERT_IMP(a_zero_flag, out_tvalid, out_tuser[0] == (out_tdata[31:0] == 32'd0))
  `VNORM_ASSERT_IMP(a_zero_units, out_tvalid && out_tuser[0], (out_tdata[127:32] == 96'd0))
  `VNORM_ASSERT_IMP(a_unit_range, out_tvalid && !out_tuser[0], unit_x_ok)

endmodule

// ===== sv/vnorm_lane_sq.sv =====
`timescale 1ns / 1ps
module vnorm_lane_sq (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] comp,
  output logic [31:0] mag_r,
  output logic        neg_r,
  output logic [63:0] sq_r
);

  logic [31:0] mag_nxt;

  // Two's complement magnitude; -2^31 gives 2^31, which still fits unsigned.
  assign mag_nxt = comp[31] ? (32'd0 - comp) : comp;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= comp[31];
      sq_r  <= 64'(mag_nxt) * 64'(mag_nxt);
    end
  end

endmodule

// ===== sv/vnorm_sqrt.sv =====
`timescale 1ns / 1ps
module vnorm_sqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [63:0]           rad,
  input  vnorm_pkg::vnorm_side_t side_in,
  output logic                  out_vld,
  output logic [31:0]           root,
  output vnorm_pkg::vnorm_side_t side_out
);

  localparam int unsigned N = vnorm_pkg::SQRT_STAGES;

  logic [31:0] root_r [1:N];
  logic [33:0] rem_r  [1:N];
  logic [63:0] rad_r  [1:N];
  vnorm_pkg::vnorm_side_t side_r [1:N];
  logic        vld_r  [1:N];

  logic [31:0] root_p [0:N-1];
  logic [33:0] rem_p  [0:N-1];
  logic [63:0] rad_p  [0:N-1];
  vnorm_pkg::vnorm_side_t side_p [0:N-1];
  logic        vld_p  [0:N-1];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic        take;

      if (k == 0) begin : g_first
        assign root_p[k] = '0;
        assign rem_p[k]  = '0;
        assign rad_p[k]  = rad;
        assign side_p[k] = side_in;
        assign vld_p[k]  = in_vld;
      end else begin : g_next
        assign root_p[k] = root_r[k];
        assign rem_p[k]  = rem_r[k];
        assign rad_p[k]  = rad_r[k];
        assign side_p[k] = side_r[k];
        assign vld_p[k]  = vld_r[k];
      end

      // One result bit per stage: bring down two radicand bits, try 4*root+1.
      assign rem_sh = {rem_p[k], rad_p[k][63:62]};
      assign trial  = {2'b00, root_p[k], 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else if (en) begin
          vld_r[k+1] <= vld_p[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          root_r[k+1] <= {root_p[k][30:0], take};
          rem_r[k+1]  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
          rad_r[k+1]  <= {rad_p[k][61:0], 2'b00};
          side_r[k+1] <= side_p[k];
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[N];
  assign root     = root_r[N];
  assign side_out = side_r[N];

endmodule

// ===== sv/vnorm_div.sv =====
`timescale 1ns / 1ps
module vnorm_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag,
  input  logic        neg,
  input  logic [31:0] len,
  output logic [30:0] quot,
  output logic        neg_out,
  output logic [31:0] len_out
);

  localparam int unsigned N = vnorm_pkg::DIV_STAGES;

  logic [31:0] rem_r  [1:N];
  logic [30:0] dvd_r  [1:N];
  logic [30:0] q_r    [1:N];
  logic        neg_r  [1:N];
  logic [31:0] len_r  [1:N];

  logic [31:0] rem_p  [0:N-1];
  logic [30:0] dvd_p  [0:N-1];
  logic [30:0] q_p    [0:N-1];
  logic        neg_p  [0:N-1];
  logic [31:0] len_p  [0:N-1];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [32:0] rem_sh;
      logic        take;

      if (k == 0) begin : g_first
        // Dividend is mag * 2^30; its top 31 bits are below the length already.
        assign rem_p[k] = {1'b0, mag[31:1]};
        assign dvd_p[k] = {mag[0], 30'd0};
        assign q_p[k]   = '0;
        assign neg_p[k] = neg;
        assign len_p[k] = len;
      end else begin : g_next
        assign rem_p[k] = rem_r[k];
        assign dvd_p[k] = dvd_r[k];
        assign q_p[k]   = q_r[k];
        assign neg_p[k] = neg_r[k];
        assign len_p[k] = len_r[k];
      end

      assign rem_sh = {rem_p[k], dvd_p[k][30]};
      assign take   = (rem_sh >= {1'b0, len_p[k]});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= take ? 32'(rem_sh - {1'b0, len_p[k]}) : rem_sh[31:0];
          dvd_r[k+1] <= {dvd_p[k][29:0], 1'b0};
          q_r[k+1]   <= {q_p[k][29:0], take};
          neg_r[k+1] <= neg_p[k];
          len_r[k+1] <= len_p[k];
        end
      end
    end
  endgenerate

  assign quot    = q_r[N];
  assign neg_out = neg_r[N];
  assign len_out = len_r[N];

endmodule

// ===== tb/vector3_normalize_core_tb.sv =====
`timescale 1ns / 1ps
module vector3_normalize_core_tb;

  // One input vector and the result that it should give.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vec3_t;

  typedef struct packed {
    logic [31:0] length;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic        zero;
  } unit_vec_t;

  localparam int WATCHDOG_LIMIT = 2000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;

  vec3_t     pending_vectors[$];
  unit_vec_t expected_units[$];
  int        error_count;
  int        in_gap;
  int        out_stall;
  int        idle_cycles;
  bit        stimulus_done;
  bit        in_fire;
  bit        out_fire;

  vector3_normalize_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor of the square root, digit by digit.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] scale_component(input logic [31:0] c,
                                                  input logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
    q = (mag << 30) / len;
    if (c[31]) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic unit_vec_t normalise(input vec3_t v);
    unit_vec_t r;
    logic [63:0] mx, my, mz, len;
    mx = v.x[31] ? (64'h1_0000_0000 - {32'd0, v.x}) : {32'd0, v.x};
    my = v.y[31] ? (64'h1_0000_0000 - {32'd0, v.y}) : {32'd0, v.y};
    mz = v.z[31] ? (64'h1_0000_0000 - {32'd0, v.z}) : {32'd0, v.z};
    len = floor_sqrt(mx * mx + my * my + mz * mz);
    r.length = len[31:0];
    if (len == 0) begin
      r.ux = 0;
      r.uy = 0;
      r.uz = 0;
      r.zero = 1'b1;
    end else begin
      r.ux = scale_component(v.x, len);
      r.uy = scale_component(v.y, len);
      r.uz = scale_component(v.z, len);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    error_count++;
  endtask

  // Random component; a fair share of edge values so sign and extreme cases recur.
  function automatic logic [31:0] random_component();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 200)) - 100);
      4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // Handshakes as seen at the rising edge, for use at the following falling edge.
  always @(posedge clk) begin
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
  end

  // Driver: presents the queued vectors, with a random gap after each.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_fire) begin
      // The previous transaction, if any, was taken at the last rising edge.
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_vectors.size() > 0) begin
        vec3_t v;
        v = pending_vectors.pop_front();
        in_tdata  <= {v.z, v.y, v.x};
        in_tvalid <= 1'b1;
        in_gap    <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_fire)
        out_stall <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
    end
  end

  // Monitor: predicts on input transactions and checks output transactions.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_units.push_back(normalise({in_tdata[31:0], in_tdata[63:32],
                                            in_tdata[95:64]}));
      if (out_tvalid && out_tready) begin
        if (expected_units.size() == 0) begin
          $display("unexpected result transaction");
          error_count++;
        end else begin
          unit_vec_t e;
          e = expected_units.pop_front();
          if (out_tdata[31:0] !== e.length)
            report_mismatch("length_out", out_tdata[31:0], e.length);
          if (out_tdata[63:32] !== e.ux)
            report_mismatch("unit_x", out_tdata[63:32], e.ux);
          if (out_tdata[95:64] !== e.uy)
            report_mismatch("unit_y", out_tdata[95:64], e.uy);
          if (out_tdata[127:96] !== e.uz)
            report_mismatch("unit_z", out_tdata[127:96], e.uz);
          if (out_tuser[0] !== e.zero)
            report_mismatch("zero_vector", {31'd0, out_tuser[0]}, {31'd0, e.zero});
        end
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (!stimulus_done || expected_units.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("vector3_normalize_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    vec3_t d;
    error_count   = 0;
    stimulus_done = 0;
    idle_cycles   = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    // Directed vectors: the zero vector, unit axes, signs and the extremes.
    pending_vectors.push_back('{32'd0, 32'd0, 32'd0});
    pending_vectors.push_back('{32'h0001_0000, 32'd0, 32'd0});
    pending_vectors.push_back('{32'd0, 32'hffff_0000, 32'd0});
    pending_vectors.push_back('{32'd0, 32'd0, 32'd1});
    pending_vectors.push_back('{32'hffff_ffff, 32'd0, 32'd0});
    pending_vectors.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_vectors.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    pending_vectors.push_back('{32'h8000_0000, 32'd0, 32'd0});
    pending_vectors.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'd1});
    pending_vectors.push_back('{32'd1, 32'd1, 32'd1});
    pending_vectors.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    pending_vectors.push_back('{32'h0003_0000, 32'h0004_0000, 32'd0});
    pending_vectors.push_back('{32'hfffd_0000, 32'd0, 32'hfffc_0000});
    pending_vectors.push_back('{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
    pending_vectors.push_back('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});
    repeat (600) begin
      d.x = random_component();
      d.y = random_component();
      d.z = random_component();
      pending_vectors.push_back(d);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_vectors.size() == 0 && !in_tvalid);
    stimulus_done = 1;
    wait (expected_units.size() == 0);
    // Allow the pipeline time to show any stray result.
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("vector3_normalize_core_tb passed");
    end else begin
      $display("vector3_normalize_core_tb failed");
    end
    $finish;
  end

endmodule

// ===== vector3_normalize_core.f =====
+incdir+sv
sv/vnorm_pkg.sv
sv/vnorm_lane_sq.sv
sv/vnorm_sqrt.sv
sv/vnorm_div.sv
sv/vector3_normalize_core.sv
tb/vector3_normalize_core_tb.sv
